// ===== rtl/core/rsp_pkg.sv =====
package rsp_pkg;

	// field widths
	localparam int TIME_W  = 48;
	localparam int CODE_W  = 32;
	localparam int CNT_W   = 5;
	localparam int CFG_IW  = 3;

	localparam int CRASH_SLOTS_DEF = 16;

	// register reset values
	localparam logic [31:0] INIT_BACKOFF_RST = 32'd250;
	localparam logic [31:0] MAX_BACKOFF_RST  = 32'd30000;
	localparam logic [31:0] HEALTHY_RST      = 32'd60000;
	localparam logic [31:0] HB_TIMEOUT_RST   = 32'd10000;
	localparam logic [31:0] WINDOW_RST       = 32'd60000;
	localparam logic [4:0]  LIMIT_RST        = 5'd5;

	// register indexes
	localparam logic [CFG_IW-1:0] CFG_INIT_BACKOFF = 3'd0;
	localparam logic [CFG_IW-1:0] CFG_MAX_BACKOFF  = 3'd1;
	localparam logic [CFG_IW-1:0] CFG_HEALTHY_TIME = 3'd2;
	localparam logic [CFG_IW-1:0] CFG_HB_TIMEOUT   = 3'd3;
	localparam logic [CFG_IW-1:0] CFG_CRASH_WINDOW = 3'd4;
	localparam logic [CFG_IW-1:0] CFG_CRASH_LIMIT  = 3'd5;

	// opcodes
	localparam logic [2:0] OP_STARTED   = 3'd0;
	localparam logic [2:0] OP_HEARTBEAT = 3'd1;
	localparam logic [2:0] OP_TICK      = 3'd2;
	localparam logic [2:0] OP_EXITED    = 3'd3;
	localparam logic [2:0] OP_START_ERR = 3'd4;
	localparam logic [2:0] OP_SHUTDOWN  = 3'd5;
	localparam logic [2:0] OP_FORCE     = 3'd6;

	// status codes
	localparam logic [2:0] STS_IDLE     = 3'd0;
	localparam logic [2:0] STS_RUNNING  = 3'd1;
	localparam logic [2:0] STS_WAIT_RST = 3'd2;
	localparam logic [2:0] STS_HUNG     = 3'd3;
	localparam logic [2:0] STS_SHUTTING = 3'd4;
	localparam logic [2:0] STS_STOPPED  = 3'd5;
	localparam logic [2:0] STS_CUTOFF   = 3'd6;

	// stop reasons
	localparam logic [1:0] RSN_NONE       = 2'd0;
	localparam logic [1:0] RSN_CLEAN      = 2'd1;
	localparam logic [1:0] RSN_SHUTDOWN   = 2'd2;
	localparam logic [1:0] RSN_CRASH_LOOP = 2'd3;

	// event codes
	localparam logic [3:0] EV_NONE      = 4'd0;
	localparam logic [3:0] EV_STARTED   = 4'd1;
	localparam logic [3:0] EV_HEARTBEAT = 4'd2;
	localparam logic [3:0] EV_HEALTHY   = 4'd3;
	localparam logic [3:0] EV_STALE     = 4'd4;
	localparam logic [3:0] EV_RESTART   = 4'd5;
	localparam logic [3:0] EV_CUTOFF    = 4'd6;
	localparam logic [3:0] EV_CLEAN     = 4'd7;
	localparam logic [3:0] EV_SHUT_REQ  = 4'd8;
	localparam logic [3:0] EV_FORCE     = 4'd9;
	localparam logic [3:0] EV_SHUT_DONE = 4'd10;

	typedef struct packed {
		logic [2:0]        opcode;
		logic [TIME_W-1:0] time_ms;
		logic [CODE_W-1:0] exit_code;
	} in_item_t;

	typedef struct packed {
		logic [2:0]        status;
		logic [1:0]        stop_reason;
		logic [3:0]        event_code;
		logic              restart;
		logic [31:0]       restart_delay;
		logic              terminate_child;
		logic              graceful_stop;
		logic              force_terminate;
		logic [CNT_W-1:0]  crash_count;
		logic [CODE_W-1:0] exit_code_out;
		logic [TIME_W-1:0] time_out;
	} out_item_t;

	typedef struct packed {
		logic [31:0] initial_backoff;
		logic [31:0] max_backoff;
		logic [31:0] healthy_time;
		logic [31:0] heartbeat_timeout;
		logic [31:0] crash_window;
		logic [4:0]  crash_limit;
	} cfg_t;

	// crash ring commands
	typedef struct packed {
		logic pop;
		logic push;
	} ring_cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_PRUNE,
		ST_PUSH,
		ST_EMIT
	} fsm_t;

	// now - then >= span, never true when then lies in the future
	function automatic logic elapsed(input logic [TIME_W-1:0] now,
	                                 input logic [TIME_W-1:0] then_t,
	                                 input logic [31:0] span);
		logic [TIME_W:0] d;
		d = {1'b0, now} - {1'b0, then_t};
		return !d[TIME_W] && (d[TIME_W-1:0] >= {{(TIME_W-32){1'b0}}, span});
	endfunction

	// now - then > span, for pruning
	function automatic logic older_than(input logic [TIME_W-1:0] now,
	                                    input logic [TIME_W-1:0] then_t,
	                                    input logic [31:0] span);
		logic [TIME_W:0] d;
		d = {1'b0, now} - {1'b0, then_t};
		return !d[TIME_W] && (d[TIME_W-1:0] > {{(TIME_W-32){1'b0}}, span});
	endfunction

	function automatic logic [31:0] double_capped(input logic [31:0] v,
	                                              input logic [31:0] cap);
		logic [32:0] d;
		d = {v, 1'b0};
		if (v >= cap)
			return cap;
		return (d < {1'b0, cap}) ? d[31:0] : cap;
	endfunction

endpackage

// ===== rtl/core/rsp_cell.sv =====
module rsp_cell
	import rsp_pkg::*;
(
	input  logic              clk,
	input  logic              shift,
	input  logic              load,
	input  logic [TIME_W-1:0] nb_data,
	input  logic [TIME_W-1:0] wdata,
	output logic [TIME_W-1:0] data
);

	logic [TIME_W-1:0] data_q;

	// a write wins over taking the neighbor's entry
	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= wdata;
		end else if (shift) begin
			data_q <= nb_data;
		end
	end

	assign data = data_q;

endmodule

// ===== rtl/core/rsp_ring.sv =====
module rsp_ring
	import rsp_pkg::*;
#(
	parameter int SLOTS = CRASH_SLOTS_DEF
) (
	input  logic                         clk,
	input  ring_cmd_t                    cmd,
	input  logic [$clog2(SLOTS+1)-1:0]   fill,
	input  logic [TIME_W-1:0]            push_data,
	output logic [TIME_W-1:0]            head
);

	localparam int FILL_W = $clog2(SLOTS + 1);

	logic [TIME_W-1:0] cell_data [SLOTS];
	logic              full;
	logic              shift;

	// oldest entry sits in cell 0; a pop moves everything one cell down
	assign full  = (fill == FILL_W'(SLOTS));
	assign shift = cmd.pop || (cmd.push && full);
	assign head  = cell_data[0];

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		logic              load;
		logic [TIME_W-1:0] nb;

		// full ring: drop the oldest and write at the tail cell
		assign load = cmd.push && (full ? (i == SLOTS - 1) : (fill == FILL_W'(i)));

		if (i == SLOTS - 1) begin : g_last
			assign nb = push_data;
		end else begin : g_mid
			assign nb = cell_data[i+1];
		end

		rsp_cell u_cell (
			.clk     (clk),
			.shift   (shift),
			.load    (load),
			.nb_data (nb),
			.wdata   (push_data),
			.data    (cell_data[i])
		);
	end

endmodule

// ===== rtl/core/restart_supervisor_policy_core.sv =====
// Flow: an accepted beat passes through the states EXEC and EMIT; a failure event (start
// failed, bad exit) passes through EXEC, PRUNE, PUSH and EMIT, and the PRUNE walk pops one
// expired crash entry per cycle from the oldest end. A new beat is taken only in IDLE, after
// the last result has moved into the output register; a result held there by out_ready low
// keeps the next result waiting in EMIT.
// Reset (arst_n low): registers to defaults, flags cleared, crash ring empty,
// next delay equal to initial_backoff; crash entries themselves are not cleared.
module restart_supervisor_policy_core
	import rsp_pkg::*;
#(
	parameter int CRASH_SLOTS = CRASH_SLOTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  in_item_t          in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output out_item_t         out_data,
	input  logic              cfg_we,
	input  logic [CFG_IW-1:0] cfg_idx,
	input  logic [31:0]       cfg_wdata
);

	localparam int FILL_W = $clog2(CRASH_SLOTS + 1);
	localparam int CMP_W  = (FILL_W > CNT_W) ? FILL_W : CNT_W;

	fsm_t state_q, state_nxt;

	cfg_t              cfg_q;
	logic [2:0]        status_q;
	logic [1:0]        reason_q;
	logic              running_q, shutdown_q, hung_q, healthy_q;
	logic [TIME_W-1:0] start_q, hb_q;
	logic [31:0]       delay_q;
	logic [FILL_W-1:0] fill_q;
	in_item_t          item_q;
	out_item_t         res_q, out_q;
	logic              out_valid_q;

	ring_cmd_t         ring_cmd;
	logic [TIME_W-1:0] ring_head;
	logic              prune_hit;
	logic              ring_full;
	logic              out_free;

	// event decode results
	logic [2:0]        ex_status;
	logic [1:0]        ex_reason;
	logic              ex_running, ex_shutdown, ex_hung, ex_healthy;
	logic [TIME_W-1:0] ex_start, ex_hb;
	logic              ex_clear, ex_fail;
	logic [3:0]        ex_ev;
	logic              ex_term, ex_grace, ex_force;
	logic [CODE_W-1:0] ex_xout;

	// failure decision
	logic [FILL_W-1:0] fill_after;
	logic [4:0]        limit;
	logic [31:0]       cap;
	logic              cutoff;
	out_item_t         fail_res;

	// crash ring
	rsp_ring #(
		.SLOTS (CRASH_SLOTS)
	) u_ring (
		.clk       (clk),
		.cmd       (ring_cmd),
		.fill      (fill_q),
		.push_data (item_q.time_ms),
		.head      (ring_head)
	);

	assign prune_hit = (fill_q != '0) &&
	                   older_than(item_q.time_ms, ring_head, cfg_q.crash_window);
	assign ring_full = (fill_q == FILL_W'(CRASH_SLOTS));
	assign out_free  = !out_valid_q || out_ready;

	// event decode
	always_comb begin
		ex_status   = status_q;
		ex_reason   = reason_q;
		ex_running  = running_q;
		ex_shutdown = shutdown_q;
		ex_hung     = hung_q;
		ex_healthy  = healthy_q;
		ex_start    = start_q;
		ex_hb       = hb_q;
		ex_clear    = 1'b0;
		ex_fail     = 1'b0;
		ex_ev       = EV_NONE;
		ex_term     = 1'b0;
		ex_grace    = 1'b0;
		ex_force    = 1'b0;
		ex_xout     = '0;
		case (item_q.opcode)
			OP_STARTED: begin
				ex_running = 1'b1;
				ex_hung    = 1'b0;
				ex_healthy = 1'b0;
				ex_start   = item_q.time_ms;
				ex_hb      = item_q.time_ms;
				ex_status  = shutdown_q ? STS_SHUTTING : STS_RUNNING;
				ex_reason  = RSN_NONE;
				ex_ev      = EV_STARTED;
			end
			OP_HEARTBEAT: begin
				if (running_q && !shutdown_q) begin
					ex_hb = item_q.time_ms;
					ex_ev = EV_HEARTBEAT;
					if (!healthy_q && elapsed(item_q.time_ms, start_q, cfg_q.healthy_time)) begin
						ex_clear   = 1'b1;
						ex_healthy = 1'b1;
						ex_ev      = EV_HEALTHY;
					end
				end
			end
			OP_TICK: begin
				if (running_q && !shutdown_q && !hung_q) begin
					if (!healthy_q && elapsed(item_q.time_ms, start_q, cfg_q.healthy_time)) begin
						ex_clear   = 1'b1;
						ex_healthy = 1'b1;
						ex_ev      = EV_HEALTHY;
					end
					if (elapsed(item_q.time_ms, hb_q, cfg_q.heartbeat_timeout)) begin
						ex_hung   = 1'b1;
						ex_status = STS_HUNG;
						ex_ev     = EV_STALE;
						ex_term   = 1'b1;
					end
				end
			end
			OP_EXITED: begin
				ex_running = 1'b0;
				if (shutdown_q) begin
					ex_status = STS_STOPPED;
					ex_reason = RSN_SHUTDOWN;
					ex_ev     = EV_SHUT_DONE;
					ex_xout   = item_q.exit_code;
				end else if (item_q.exit_code == '0 && !hung_q) begin
					ex_status = STS_STOPPED;
					ex_reason = RSN_CLEAN;
					ex_ev     = EV_CLEAN;
				end else begin
					ex_fail = 1'b1;
				end
			end
			OP_START_ERR: begin
				ex_fail = 1'b1;
			end
			OP_SHUTDOWN: begin
				ex_shutdown = 1'b1;
				if (running_q) begin
					ex_status = STS_SHUTTING;
					ex_reason = RSN_NONE;
					ex_ev     = EV_SHUT_REQ;
					ex_grace  = 1'b1;
				end else begin
					ex_status = STS_STOPPED;
					ex_reason = RSN_SHUTDOWN;
					ex_ev     = EV_SHUT_DONE;
				end
			end
			OP_FORCE: begin
				if (shutdown_q && running_q) begin
					ex_status = STS_SHUTTING;
					ex_ev     = EV_FORCE;
					ex_force  = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// failure: record crash, then cut off or schedule a restart
	always_comb begin
		fill_after = ring_full ? fill_q : fill_q + FILL_W'(1);
		limit      = (cfg_q.crash_limit == '0) ? 5'd1 : cfg_q.crash_limit;
		cap        = (cfg_q.max_backoff < cfg_q.initial_backoff) ?
		             cfg_q.initial_backoff : cfg_q.max_backoff;
		cutoff     = CMP_W'(fill_after) >= CMP_W'(limit);

		fail_res                 = '0;
		fail_res.status          = cutoff ? STS_CUTOFF : STS_WAIT_RST;
		fail_res.stop_reason     = cutoff ? RSN_CRASH_LOOP : reason_q;
		fail_res.event_code      = cutoff ? EV_CUTOFF : EV_RESTART;
		fail_res.restart         = !cutoff;
		fail_res.restart_delay   = cutoff ? 32'd0 : delay_q;
		fail_res.crash_count     = CNT_W'(fill_after);
		fail_res.exit_code_out   = (item_q.opcode == OP_EXITED) ? item_q.exit_code : '0;
		fail_res.time_out        = item_q.time_ms;
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE:  if (in_valid) state_nxt = ST_EXEC;
			ST_EXEC:  state_nxt = ex_fail ? ST_PRUNE : ST_EMIT;
			ST_PRUNE: if (!prune_hit) state_nxt = ST_PUSH;
			ST_PUSH:  state_nxt = ST_EMIT;
			ST_EMIT:  if (out_free) state_nxt = ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	// state-driven controls
	always_comb begin
		in_ready      = 1'b0;
		ring_cmd.pop  = 1'b0;
		ring_cmd.push = 1'b0;
		case (state_q)
			ST_IDLE:  in_ready = 1'b1;
			ST_PRUNE: ring_cmd.pop = prune_hit;
			ST_PUSH:  ring_cmd.push = 1'b1;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// configuration registers; initial_backoff also reloads the delay
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.initial_backoff   <= INIT_BACKOFF_RST;
			cfg_q.max_backoff       <= MAX_BACKOFF_RST;
			cfg_q.healthy_time      <= HEALTHY_RST;
			cfg_q.heartbeat_timeout <= HB_TIMEOUT_RST;
			cfg_q.crash_window      <= WINDOW_RST;
			cfg_q.crash_limit       <= LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_INIT_BACKOFF: cfg_q.initial_backoff   <= cfg_wdata;
				CFG_MAX_BACKOFF:  cfg_q.max_backoff       <= cfg_wdata;
				CFG_HEALTHY_TIME: cfg_q.healthy_time      <= cfg_wdata;
				CFG_HB_TIMEOUT:   cfg_q.heartbeat_timeout <= cfg_wdata;
				CFG_CRASH_WINDOW: cfg_q.crash_window      <= cfg_wdata;
				CFG_CRASH_LIMIT:  cfg_q.crash_limit       <= cfg_wdata[4:0];
				default: begin
				end
			endcase
		end
	end

	// supervisor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q   <= STS_IDLE;
			reason_q   <= RSN_NONE;
			running_q  <= 1'b0;
			shutdown_q <= 1'b0;
			hung_q     <= 1'b0;
			healthy_q  <= 1'b0;
			start_q    <= '0;
			hb_q       <= '0;
			delay_q    <= INIT_BACKOFF_RST;
			fill_q     <= '0;
		end else begin
			if (cfg_we && cfg_idx == CFG_INIT_BACKOFF) begin
				delay_q <= cfg_wdata;
			end
			case (state_q)
				ST_EXEC: begin
					status_q   <= ex_status;
					reason_q   <= ex_reason;
					running_q  <= ex_running;
					shutdown_q <= ex_shutdown;
					hung_q     <= ex_hung;
					healthy_q  <= ex_healthy;
					start_q    <= ex_start;
					hb_q       <= ex_hb;
					if (ex_clear) begin
						fill_q  <= '0;
						delay_q <= cfg_q.initial_backoff;
					end
				end
				ST_PRUNE: begin
					if (prune_hit) fill_q <= fill_q - FILL_W'(1);
				end
				ST_PUSH: begin
					running_q <= 1'b0;
					fill_q    <= fill_after;
					status_q  <= fail_res.status;
					reason_q  <= fail_res.stop_reason;
					if (!cutoff) delay_q <= double_capped(delay_q, cap);
				end
				default: begin
				end
			endcase
		end
	end

	// input capture and result staging
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_q <= in_data;
		end
		if (state_q == ST_EXEC && !ex_fail) begin
			res_q.status          <= ex_status;
			res_q.stop_reason     <= ex_reason;
			res_q.event_code      <= ex_ev;
			res_q.restart         <= 1'b0;
			res_q.restart_delay   <= '0;
			res_q.terminate_child <= ex_term;
			res_q.graceful_stop   <= ex_grace;
			res_q.force_terminate <= ex_force;
			res_q.crash_count     <= ex_clear ? '0 : CNT_W'(fill_q);
			res_q.exit_code_out   <= ex_xout;
			res_q.time_out        <= item_q.time_ms;
		end else if (state_q == ST_PUSH) begin
			res_q <= fail_res;
		end
		if (state_q == ST_EMIT && out_free) begin
			out_q <= res_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// checks
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(CRASH_SLOTS))
		else $error("crash fill exceeds ring size");

	a_delay_only_on_restart: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.restart || out_q.restart_delay == '0))
		else $error("restart delay without restart");

	a_cutoff_reason: assert property (@(posedge clk) disable iff (!arst_n)
		status_q == STS_CUTOFF |-> reason_q == RSN_CRASH_LOOP)
		else $error("cutoff status without crash loop reason");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		ring_cmd.pop |-> (fill_q != '0 && state_q == ST_PRUNE))
		else $error("crash ring popped while empty");

endmodule

// ===== verif/tb_restart_supervisor_policy_core.sv =====
module tb_restart_supervisor_policy_core;
	timeunit 1ns;
	timeprecision 1ps;

	import rsp_pkg::*;

	localparam int SETTLE_CYCLES = 24;
	localparam int LONG_HOLD     = 300;
	localparam int STALL_LIMIT   = 3000;
	localparam int SHOW_LIMIT    = 10;
	localparam logic [CFG_IW-1:0] CFG_SPARE_LO = CFG_CRASH_LIMIT + 3'd1;
	localparam logic [TIME_W-1:0] TIME_MAX = '1;
	localparam logic [2:0]        OP_SPARE = 3'd7;

	typedef enum {RX_OPEN, RX_COIN, RX_STINGY, RX_EAGER} rx_mode_t;

	// Tracks the supervisor decisions the block must produce, in order.
	class decision_board;
		out_item_t decision_q[$];
		int mismatches;

		// register copies
		logic [31:0] init_backoff, max_backoff, healthy_span, beat_timeout, crash_span;
		logic [4:0]  crash_limit;

		// supervisor state
		logic [2:0]  status;
		logic [1:0]  reason;
		logic        running, shut_seen, hung, healthy_done;
		logic [47:0] t_start, t_beat;
		logic [31:0] next_delay;
		logic [47:0] crash_times [CRASH_SLOTS_DEF];
		int          head, fill;

		function new();
			init_backoff = INIT_BACKOFF_RST;
			max_backoff  = MAX_BACKOFF_RST;
			healthy_span = HEALTHY_RST;
			beat_timeout = HB_TIMEOUT_RST;
			crash_span   = WINDOW_RST;
			crash_limit  = LIMIT_RST;
			status       = STS_IDLE;
			reason       = RSN_NONE;
			running      = 1'b0;
			shut_seen    = 1'b0;
			hung         = 1'b0;
			healthy_done = 1'b0;
			t_start      = '0;
			t_beat       = '0;
			next_delay   = INIT_BACKOFF_RST;
			head         = 0;
			fill         = 0;
			mismatches   = 0;
		endfunction

		function int pending();
			return decision_q.size();
		endfunction

		function void write_reg(logic [CFG_IW-1:0] idx, logic [31:0] data);
			case (idx)
				CFG_INIT_BACKOFF: begin
					init_backoff = data;
					next_delay   = data;
				end
				CFG_MAX_BACKOFF:  max_backoff  = data;
				CFG_HEALTHY_TIME: healthy_span = data;
				CFG_HB_TIMEOUT:   beat_timeout = data;
				CFG_CRASH_WINDOW: crash_span   = data;
				CFG_CRASH_LIMIT:  crash_limit  = data[4:0];
				default: ;
			endcase
		endfunction

		// true once at least span ms passed; a future timestamp never counts
		function bit aged(logic [47:0] now, logic [47:0] since, logic [31:0] span);
			return now >= since && (now - since) >= {16'd0, span};
		endfunction

		function logic [31:0] doubled(logic [31:0] v, logic [31:0] cap);
			logic [32:0] twice;
			twice = {1'b0, v} + {1'b0, v};
			return (v >= cap || twice >= {1'b0, cap}) ? cap : twice[31:0];
		endfunction

		function void clear_history();
			head         = 0;
			fill         = 0;
			next_delay   = init_backoff;
			healthy_done = 1'b1;
		endfunction

		function void note_event(in_item_t beat);
			out_item_t   r;
			logic [47:0] now;
			logic [31:0] cap;
			logic [3:0]  ev;
			bit          failure;
			int          lim;
			r       = '0;
			now     = beat.time_ms;
			ev      = EV_NONE;
			failure = 1'b0;
			case (beat.opcode)
				OP_STARTED: begin
					running      = 1'b1;
					hung         = 1'b0;
					healthy_done = 1'b0;
					t_start      = now;
					t_beat       = now;
					status       = shut_seen ? STS_SHUTTING : STS_RUNNING;
					reason       = RSN_NONE;
					ev           = EV_STARTED;
				end
				OP_HEARTBEAT: begin
					if (running && !shut_seen) begin
						t_beat = now;
						ev     = EV_HEARTBEAT;
						if (!healthy_done && aged(now, t_start, healthy_span)) begin
							clear_history();
							ev = EV_HEALTHY;
						end
					end
				end
				OP_TICK: begin
					if (running && !shut_seen && !hung) begin
						if (!healthy_done && aged(now, t_start, healthy_span)) begin
							clear_history();
							ev = EV_HEALTHY;
						end
						// stale heartbeat overrides the healthy note
						if (aged(now, t_beat, beat_timeout)) begin
							hung              = 1'b1;
							status            = STS_HUNG;
							ev                = EV_STALE;
							r.terminate_child = 1'b1;
						end
					end
				end
				OP_EXITED: begin
					running = 1'b0;
					if (shut_seen) begin
						status          = STS_STOPPED;
						reason          = RSN_SHUTDOWN;
						ev              = EV_SHUT_DONE;
						r.exit_code_out = beat.exit_code;
					end else if (beat.exit_code == '0 && !hung) begin
						status = STS_STOPPED;
						reason = RSN_CLEAN;
						ev     = EV_CLEAN;
					end else begin
						failure         = 1'b1;
						r.exit_code_out = beat.exit_code;
					end
				end
				OP_START_ERR: failure = 1'b1;
				OP_SHUTDOWN: begin
					shut_seen = 1'b1;
					if (running) begin
						status          = STS_SHUTTING;
						reason          = RSN_NONE;
						ev              = EV_SHUT_REQ;
						r.graceful_stop = 1'b1;
					end else begin
						status = STS_STOPPED;
						reason = RSN_SHUTDOWN;
						ev     = EV_SHUT_DONE;
					end
				end
				OP_FORCE: begin
					if (shut_seen && running) begin
						status            = STS_SHUTTING;
						ev                = EV_FORCE;
						r.force_terminate = 1'b1;
					end
				end
				default: ;
			endcase

			// failure: prune the ring from its oldest end, record, then restart or cut off
			if (failure) begin
				lim     = (crash_limit == '0) ? 1 : int'(crash_limit);
				cap     = (max_backoff < init_backoff) ? init_backoff : max_backoff;
				running = 1'b0;
				while (fill != 0 && now >= crash_times[head] &&
				       (now - crash_times[head]) > {16'd0, crash_span}) begin
					head = (head + 1) % CRASH_SLOTS_DEF;
					fill--;
				end
				if (fill >= CRASH_SLOTS_DEF) begin
					crash_times[head] = now;
					head = (head + 1) % CRASH_SLOTS_DEF;
				end else begin
					crash_times[(head + fill) % CRASH_SLOTS_DEF] = now;
					fill++;
				end
				if (fill >= lim) begin
					status = STS_CUTOFF;
					reason = RSN_CRASH_LOOP;
					ev     = EV_CUTOFF;
				end else begin
					status          = STS_WAIT_RST;
					ev              = EV_RESTART;
					r.restart       = 1'b1;
					r.restart_delay = next_delay;
					next_delay      = doubled(next_delay, cap);
				end
			end

			r.status      = status;
			r.stop_reason = reason;
			r.event_code  = ev;
			r.crash_count = fill[4:0];
			r.time_out    = now;
			decision_q = {decision_q, r};
		endfunction

		function void field(string name, logic [63:0] want, logic [63:0] got,
		                    logic [47:0] stamp);
			if (want !== got) begin
				mismatches++;
				if (mismatches <= SHOW_LIMIT)
					$display("mismatch %s at event time %0h: expected %0h, got %0h",
					         name, stamp, want, got);
			end
		endfunction

		function void check_decision(out_item_t got);
			out_item_t want;
			if (decision_q.size() == 0) begin
				mismatches++;
				if (mismatches <= SHOW_LIMIT)
					$display("unexpected result beat: %h", got);
				return;
			end
			want = decision_q[0];
			decision_q.delete(0);
			field("status", 64'(want.status), 64'(got.status), want.time_out);
			field("stop_reason", 64'(want.stop_reason), 64'(got.stop_reason), want.time_out);
			field("event_code", 64'(want.event_code), 64'(got.event_code), want.time_out);
			field("restart", 64'(want.restart), 64'(got.restart), want.time_out);
			field("restart_delay", 64'(want.restart_delay), 64'(got.restart_delay),
			      want.time_out);
			field("terminate_child", 64'(want.terminate_child), 64'(got.terminate_child),
			      want.time_out);
			field("graceful_stop", 64'(want.graceful_stop), 64'(got.graceful_stop),
			      want.time_out);
			field("force_terminate", 64'(want.force_terminate), 64'(got.force_terminate),
			      want.time_out);
			field("crash_count", 64'(want.crash_count), 64'(got.crash_count), want.time_out);
			field("exit_code_out", 64'(want.exit_code_out), 64'(got.exit_code_out),
			      want.time_out);
			field("time_out", 64'(want.time_out), 64'(got.time_out), want.time_out);
		endfunction
	endclass

	logic              clk;
	logic              arst_n    = 1'b0;
	logic              in_valid  = 1'b0;
	logic              in_ready;
	in_item_t          in_data   = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	out_item_t         out_data;
	logic              cfg_we    = 1'b0;
	logic [CFG_IW-1:0] cfg_idx   = '0;
	logic [31:0]       cfg_wdata = '0;

	decision_board sb = new();

	bit          hold_go     = 1'b0;
	bit          gaps_on     = 1'b1;
	bit          shutdown_ok = 1'b0;
	int          burst_left  = 0;
	int          sent        = 0;
	int          step_max    = 100;
	logic [47:0] now_ms      = '0;
	int          quiet_cycles;

	restart_supervisor_policy_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result side: check every accepted beat
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_decision(out_data);
	end

	// cycles with no beat on either side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			quiet_cycles <= 0;
		else if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		@(posedge arst_n);
		while (quiet_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("DONE: errors detected");
		$finish;
	end

	// receiver: stall pattern in stretches, one long hold-off on request
	initial begin
		rx_mode_t mode;
		int       left;
		bit       held;
		mode = RX_OPEN;
		left = 0;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_go && !held) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			if (left == 0) begin
				mode = rx_mode_t'($urandom_range(0, 3));
				left = $urandom_range(16, 160);
			end
			left--;
			case (mode)
				RX_OPEN:   out_ready <= 1'b1;
				RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
				RX_STINGY: out_ready <= ($urandom_range(0, 9) == 0);
				default:   out_ready <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	// sender pacing: bursts of random length, random gaps between
	task automatic pace();
		int gap;
		if (burst_left != 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 24);
			gap = gaps_on ? $urandom_range(0, 12) : 0;
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic send(input logic [2:0] op, input logic [47:0] t, input logic [31:0] code);
		in_item_t beat;
		beat.opcode    = op;
		beat.time_ms   = t;
		beat.exit_code = code;
		in_data  <= beat;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_event(beat);
		sent++;
		pace();
	endtask

	// random event: time mostly moves forward, sometimes back, rarely anywhere
	task automatic emit(input logic [2:0] op, input logic [31:0] code);
		logic [47:0] t;
		logic [63:0] wide;
		int          roll;
		roll = $urandom_range(0, 99);
		if (roll < 4)
			now_ms = now_ms - 48'($urandom_range(0, step_max * 4));
		else
			now_ms = now_ms + 48'($urandom_range(0, step_max));
		t = now_ms;
		if (roll >= 96) begin
			wide = {$urandom(), $urandom()};
			t = wide[47:0];
		end
		if ($urandom_range(0, 99) < 8) begin
			op = 3'($urandom_range(0, 7));
			if (op == OP_SHUTDOWN && !shutdown_ok)
				op = OP_FORCE;
			code = $urandom();
		end
		send(op, t, code);
	endtask

	// one run of the child: start, some liveness traffic, then an ending
	task automatic episode();
		int         n;
		int         pick;
		logic [2:0] op;
		if ($urandom_range(0, 9) != 0)
			emit(OP_STARTED, $urandom());
		n = $urandom_range(0, 6);
		repeat (n)
			emit(($urandom_range(0, 2) != 0) ? OP_HEARTBEAT : OP_TICK, $urandom());
		pick = $urandom_range(0, 99);
		if (pick < 45)
			emit(OP_EXITED, ($urandom_range(0, 1) != 0) ? $urandom()
			                                             : 32'($urandom_range(1, 255)));
		else if (pick < 65)
			emit(OP_START_ERR, $urandom());
		else if (pick < 85)
			emit(OP_EXITED, '0);
		else begin
			// shutdown is held back until the final phase
			op = 3'($urandom_range(0, 6));
			if (op == OP_SHUTDOWN && !shutdown_ok)
				op = OP_FORCE;
			emit(op, $urandom());
		end
	endtask

	// wait for every outstanding decision, then let the block go quiet
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic reg_beat(input logic [CFG_IW-1:0] idx, input logic [31:0] data);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	task automatic program_regs(input logic [31:0] init_v, max_v, healthy_v, beat_v,
	                            window_v, input logic [4:0] limit_v);
		reg_beat(CFG_INIT_BACKOFF, init_v);
		reg_beat(CFG_MAX_BACKOFF, max_v);
		reg_beat(CFG_HEALTHY_TIME, healthy_v);
		reg_beat(CFG_HB_TIMEOUT, beat_v);
		reg_beat(CFG_CRASH_WINDOW, window_v);
		// upper data bits must not reach the 5-bit limit
		reg_beat(CFG_CRASH_LIMIT, {27'($urandom()), limit_v});
		// index with no register behind it
		reg_beat(CFG_IW'($urandom_range(int'(CFG_SPARE_LO), (1 << CFG_IW) - 1)), $urandom());
		cfg_we <= 1'b0;
	endtask

	task automatic random_phase(input logic [31:0] init_v, max_v, healthy_v, beat_v,
	                            window_v, input logic [4:0] limit_v, input int step,
	                            input int count);
		int goal;
		settle();
		program_regs(init_v, max_v, healthy_v, beat_v, window_v, limit_v);
		step_max = step;
		goal = sent + count;
		while (sent < goal)
			episode();
	endtask

	initial begin
		logic [31:0] r_init, r_max, r_healthy, r_beat, r_window;
		logic [4:0]  r_limit;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: idle events, stale detection, healthy clear, crash loop, time wrap
		send(OP_SPARE, '0, '1);             // unused opcode
		send(OP_HEARTBEAT, 48'd5, '0);      // nothing running
		send(OP_TICK, 48'd6, '0);
		send(OP_FORCE, 48'd7, '0);          // no shutdown yet
		send(OP_STARTED, 48'd100, '0);
		send(OP_HEARTBEAT, 48'd200, '0);
		send(OP_TICK, 48'd10199, '0);       // one short of stale
		send(OP_TICK, 48'd10200, '0);       // stale, hung
		send(OP_TICK, 48'd10300, '0);       // ignored while hung
		send(OP_EXITED, 48'd10400, '0);     // clean code but hung: failure
		send(OP_STARTED, 48'd20000, '0);
		send(OP_HEARTBEAT, 48'd80000, '0);  // healthy clear
		send(OP_EXITED, 48'd80001, '0);     // clean stop
		for (int i = 0; i < 5; i++)         // backoff doubling then cutoff
			send(OP_START_ERR, 48'd80002 + 48'(i), '1);
		send(OP_STARTED, TIME_MAX, '0);
		send(OP_TICK, 48'd5, '0);           // time went backwards: not stale
		send(OP_EXITED, TIME_MAX, 32'h8000_0001);

		// random phases over several register settings
		now_ms = 48'd1_000_000;
		random_phase(INIT_BACKOFF_RST, MAX_BACKOFF_RST, HEALTHY_RST, HB_TIMEOUT_RST,
		             WINDOW_RST, LIMIT_RST, 15000, 110);

		settle();
		program_regs(32'd3, 32'd40, 32'd400, 32'd60, 32'd300, 5'd4);
		hold_go <= 1'b1;                    // receiver holds off while beats keep coming
		step_max = 80;
		begin
			int goal;
			goal = sent + 110;
			while (sent < goal)
				episode();
		end

		random_phase('0, '0, '0, '0, '0, 5'd0, 4, 90);
		gaps_on = 1'b0;
		random_phase('1, '1, '1, '1, '1, 5'd16, 50, 100);
		gaps_on = 1'b1;
		// cap below the initial delay, limit above the ring size
		random_phase(32'd100, 32'd7, 32'd5000, 32'd900, 32'd100000, 5'd31, 200, 110);
		random_phase(32'h6000_0000, 32'hFFFF_FFF0, 32'd700, 32'd90, 32'd500, 5'd17, 120, 100);
		r_init    = $urandom_range(0, 500);
		r_max     = $urandom_range(0, 5000);
		r_healthy = $urandom_range(0, 3000);
		r_beat    = $urandom_range(0, 500);
		r_window  = $urandom_range(0, 3000);
		r_limit   = 5'($urandom_range(0, 16));
		random_phase(r_init, r_max, r_healthy, r_beat, r_window, r_limit, 300, 100);

		// shutdown sticks until reset, so it comes last
		settle();
		program_regs(32'd7, 32'd500, 32'd1000, 32'd100, 32'd800, 5'd3);
		shutdown_ok = 1'b1;
		now_ms = now_ms + 48'd10000;
		send(OP_STARTED, now_ms, '0);
		send(OP_SHUTDOWN, now_ms + 48'd1, '0);   // graceful stop
		send(OP_HEARTBEAT, now_ms + 48'd2, '0);  // ignored
		send(OP_TICK, now_ms + 48'd3, '0);       // ignored
		send(OP_FORCE, now_ms + 48'd4, '0);
		send(OP_EXITED, now_ms + 48'd5, 32'hA5A5_5A5A);
		send(OP_FORCE, now_ms + 48'd6, '0);      // nothing running
		send(OP_SHUTDOWN, now_ms + 48'd7, '0);   // done at once
		send(OP_STARTED, now_ms + 48'd8, '0);
		send(OP_START_ERR, now_ms + 48'd9, '1);
		now_ms = now_ms + 48'd10;
		step_max = 150;
		begin
			int goal;
			goal = sent + 40;
			while (sent < goal)
				episode();
		end

		settle();
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
